>>> sv/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg: shared types and constants of the indexed sequence store
// Command and status codes, word structs and the control struct broadcast to the cells.
// ----------------------------------------------------------------------------
package isq_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int GRP_SIZE = 8;
  localparam int GRP_N    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_INS_FRT = 3'd1;
  localparam logic [2:0] CMD_INS_END = 3'd2;
  localparam logic [2:0] CMD_INS_POS = 3'd3;
  localparam logic [2:0] CMD_DEL_POS = 3'd4;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef struct packed {
    logic [2:0]              cmd;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] data_in;
  } isq_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [1:0]               status;
    logic [CNT_W-1:0]         element_count;
  } isq_res_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] data;
  } isq_ctrl_t;

endpackage

>>> sv/isq_cell.sv
// ----------------------------------------------------------------------------
// isq_cell: one storage cell of the sequence chain
// Holds one element; on insert takes the left neighbor or the new word, on
// delete takes the right neighbor. Drives its word onto the read tree on a hit.
// ----------------------------------------------------------------------------
module isq_cell
  import isq_pkg::*;
(
  input  logic                     clk_i,
  input  logic [POS_W-1:0]         index_i,
  input  isq_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] prev_i,
  input  logic signed [DATA_W-1:0] next_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic signed [DATA_W-1:0] hit_o
);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     en;

  always_comb begin
    val_d = val_q;
    en    = 1'b0;
    if (ctrl_i.ins) begin
      if (index_i > ctrl_i.pos) begin
        val_d = prev_i;
        en    = 1'b1;
      end else if (index_i == ctrl_i.pos) begin
        val_d = ctrl_i.data;
        en    = 1'b1;
      end
    end else if (ctrl_i.del && (index_i >= ctrl_i.pos)) begin
      val_d = next_i;
      en    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign hit_o = (index_i == ctrl_i.pos) ? val_q : '0;

endmodule

>>> sv/indexed_sequence_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit: bounded ordered store of signed words
// A chain of cells that shifts up on insert and down on delete, with a
// registered OR tree for reads at a position.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  command   item_i                      start, busy (taken on start && !busy)
//  result    res_o                       res_valid_o, one-cycle strobe
//
// per command, the accept edge shifts the chain and loads the group stage of
// the read tree, and the edge that ends the busy cycle loads the result word
// busy is high for the one cycle between; a new command may start while the
// result strobe is up
// reset clears the element count and control; cell contents need no reset
// the receiver cannot stall: each result is shown for exactly one cycle
module indexed_sequence_store_unit
  import isq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  isq_cmd_t item_i,
  output logic     res_valid_o,
  output isq_res_t res_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PEND = 1'b1;

  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_ONES = 2'd1;
  localparam logic [1:0] RD_DATA = 2'd2;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       status_q, status_d;
  logic [1:0]       rd_mode_q, rd_mode_d;
  logic             res_valid_q;
  isq_res_t         res_q;
  logic             accept;

  logic [POS_W-1:0] ins_pos;
  logic             ins_ok, del_ok;
  isq_ctrl_t        ctrl;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] cell_hit [CAPACITY];
  logic signed [DATA_W-1:0] grp_q    [GRP_N];
  logic signed [DATA_W-1:0] grp_d    [GRP_N];
  logic signed [DATA_W-1:0] rd_word;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_PEND);

  // decode the command against the current count
  always_comb begin
    ins_pos   = item_i.position;
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    status_d  = STAT_DONE;
    rd_mode_d = RD_ZERO;
    count_d   = count_q;
    case (item_i.cmd)
      CMD_INS_FRT: ins_pos = '0;
      CMD_INS_END: ins_pos = POS_W'(count_q);
      default:     ins_pos = item_i.position;
    endcase
    case (item_i.cmd)
      CMD_READ: begin
        if (POS_W'(item_i.position) < POS_W'(count_q)) begin
          rd_mode_d = RD_DATA;
        end else begin
          rd_mode_d = RD_ONES;
          status_d  = STAT_RANGE;
        end
      end
      CMD_INS_FRT, CMD_INS_END, CMD_INS_POS: begin
        if (ins_pos > POS_W'(count_q)) begin
          status_d = STAT_RANGE;
        end else if (count_q >= CAP_CNT) begin
          status_d = STAT_FULL;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_DEL_POS: begin
        if (item_i.position >= POS_W'(count_q)) begin
          status_d = STAT_RANGE;
        end else begin
          del_ok  = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl.ins  = accept && ins_ok;
    ctrl.del  = accept && del_ok;
    ctrl.pos  = (item_i.cmd == CMD_READ || item_i.cmd == CMD_DEL_POS) ? item_i.position
                                                                       : ins_pos;
    ctrl.data = item_i.data_in;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_p
      assign prev_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_n
      assign next_w = cell_val[i+1];
    end
    isq_cell u_cell (
      .clk_i  (clk_i),
      .index_i(POS_W'(i)),
      .ctrl_i (ctrl),
      .prev_i (prev_w),
      .next_i (next_w),
      .val_o  (cell_val[i]),
      .hit_o  (cell_hit[i])
    );
  end

  // first level of the read tree: one OR per group of cells
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_hit[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < GRP_N; g++) begin
      rd_word = rd_word | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grp_q     <= grp_d;
      status_q  <= status_d;
      rd_mode_q <= rd_mode_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_PEND;
      ST_PEND: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_PEND);
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PEND) begin
      case (rd_mode_q)
        RD_DATA: res_q.read_data <= rd_word;
        RD_ONES: res_q.read_data <= '1;
        default: res_q.read_data <= '0;
      endcase
      res_q.status        <= status_q;
      res_q.element_count <= count_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after an accepted command");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_valid_o)
    else $error("result strobe missing after busy cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("element count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == STAT_FULL) |-> res_o.element_count == CAP_CNT)
    else $error("full status reported with room left");

  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for two cycles");

endmodule
